/* design/krt_pkg.sv */
// ----------------------------------------------------------------------------
// krt_pkg: shared types and codes for the keyed record table
// Request codes, status codes, the stored record layout, the sequencer
// states and the result bundle that goes from the sequencer to the top level.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned SAL_W    = 32;
    localparam int unsigned SECTOR_W = 8;
    localparam int unsigned STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [SAL_W-1:0]    salary;
        logic                sex;
        logic [SECTOR_W-1:0] sector;
    } t_rec;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [SAL_W-1:0]    salary;
        logic                sex;
        logic [SECTOR_W-1:0] sector;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } t_state;

endpackage

/* design/krt_ram.sv */
// ----------------------------------------------------------------------------
// krt_ram: record store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module krt_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 74
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/krt_ctrl.sv */
// ----------------------------------------------------------------------------
// krt_ctrl: request sequencer and slot compare unit
// Sweeps the store one slot a cycle, tracks the first free slot and the first
// live slot with the request key, then writes back and forms the result.
// ----------------------------------------------------------------------------
module krt_ctrl #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_req_valid,
    output logic                                      o_req_ready,
    input  logic [krt_pkg::OP_W-1:0]                  i_req_op,
    input  logic [krt_pkg::KEY_W-1:0]                 i_req_key,
    input  logic [krt_pkg::SAL_W-1:0]                 i_req_salary,
    input  logic                                      i_req_sex,
    input  logic [krt_pkg::SECTOR_W-1:0]              i_req_sector,
    output logic                                      o_ram_we,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_ram_waddr,
    output krt_pkg::t_rec                             o_ram_wdata,
    output logic                                      o_ram_re,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_ram_raddr,
    input  krt_pkg::t_rec                             i_ram_rdata,
    input  logic                                      i_res_free,
    output krt_pkg::t_result                          o_res
);

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    krt_pkg::t_state r_state, n_state;
    logic                          r_init, n_init;
    logic [AW-1:0]                 r_addr, n_addr;
    logic                          r_dv, n_dv;
    logic [AW-1:0]                 r_didx, n_didx;
    logic [krt_pkg::OP_W-1:0]      r_op, n_op;
    logic [krt_pkg::KEY_W-1:0]     r_key, n_key;
    logic [krt_pkg::SAL_W-1:0]     r_sal, n_sal;
    logic                          r_sex, n_sex;
    logic [krt_pkg::SECTOR_W-1:0]  r_sec, n_sec;
    logic                          r_free_found, n_free_found;
    logic [AW-1:0]                 r_free_idx, n_free_idx;
    logic                          r_hit, n_hit;
    logic [AW-1:0]                 r_hit_idx, n_hit_idx;
    krt_pkg::t_rec                 r_hit_rec, n_hit_rec;
    logic                          w_last;

    assign w_last = (r_addr == LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krt_pkg::ST_CLR;
            r_init  <= 1'b1;
            r_addr  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_addr  <= n_addr;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx       <= n_didx;
        r_op         <= n_op;
        r_key        <= n_key;
        r_sal        <= n_sal;
        r_sex        <= n_sex;
        r_sec        <= n_sec;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_rec    <= n_hit_rec;
    end

    always_comb begin
        n_state      = r_state;
        n_init       = r_init;
        n_addr       = r_addr;
        n_dv         = 1'b0;
        n_didx       = r_addr;
        n_op         = r_op;
        n_key        = r_key;
        n_sal        = r_sal;
        n_sex        = r_sex;
        n_sec        = r_sec;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_rec    = r_hit_rec;
        o_req_ready  = 1'b0;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_addr;
        o_ram_wdata  = '0;
        o_ram_re     = 1'b0;
        o_ram_raddr  = r_addr;
        o_res        = '0;

        // compare the slot read in the previous cycle
        if (r_dv) begin
            if (!i_ram_rdata.valid && !r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = r_didx;
            end
            if (i_ram_rdata.valid && (i_ram_rdata.key == r_key) && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_didx;
                n_hit_rec = i_ram_rdata;
            end
        end

        case (r_state)
            krt_pkg::ST_CLR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_addr;
                if (w_last) begin
                    n_addr = '0;
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = krt_pkg::ST_IDLE;
                    end else begin
                        n_state = krt_pkg::ST_DONE;
                    end
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            krt_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_op         = i_req_op;
                    n_key        = i_req_key;
                    n_sal        = i_req_salary;
                    n_sex        = i_req_sex;
                    n_sec        = i_req_sector;
                    n_addr       = '0;
                    n_free_found = 1'b0;
                    n_hit        = 1'b0;
                    if (i_req_op == krt_pkg::OP_CLEAR) begin
                        n_state = krt_pkg::ST_CLR;
                    end else begin
                        n_state = krt_pkg::ST_SCAN;
                    end
                end
            end
            krt_pkg::ST_SCAN: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_addr;
                n_dv        = 1'b1;
                n_didx      = r_addr;
                if (w_last) begin
                    n_addr  = '0;
                    n_state = krt_pkg::ST_TAIL;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            krt_pkg::ST_TAIL: begin
                n_state = krt_pkg::ST_DONE;
            end
            krt_pkg::ST_DONE: begin
                if (i_res_free) begin
                    o_res.valid  = 1'b1;
                    o_res.status = krt_pkg::STAT_OK;
                    n_state      = krt_pkg::ST_IDLE;
                    case (r_op)
                        krt_pkg::OP_INSERT: begin
                            if (!r_free_found) begin
                                o_res.status = krt_pkg::STAT_FULL;
                            end else if (r_hit) begin
                                o_res.status = krt_pkg::STAT_DUP;
                            end else begin
                                o_ram_we           = 1'b1;
                                o_ram_waddr        = r_free_idx;
                                o_ram_wdata.valid  = 1'b1;
                                o_ram_wdata.key    = r_key;
                                o_ram_wdata.salary = r_sal;
                                o_ram_wdata.sex    = r_sex;
                                o_ram_wdata.sector = r_sec;
                            end
                        end
                        krt_pkg::OP_DELETE: begin
                            if (!r_hit) begin
                                o_res.status = krt_pkg::STAT_MISSING;
                            end else begin
                                o_ram_we          = 1'b1;
                                o_ram_waddr       = r_hit_idx;
                                o_ram_wdata       = r_hit_rec;
                                o_ram_wdata.valid = 1'b0;
                            end
                        end
                        krt_pkg::OP_UPDATE: begin
                            if (!r_hit) begin
                                o_res.status = krt_pkg::STAT_MISSING;
                            end else begin
                                o_ram_we           = 1'b1;
                                o_ram_waddr        = r_hit_idx;
                                o_ram_wdata        = r_hit_rec;
                                o_ram_wdata.salary = r_sal;
                            end
                        end
                        krt_pkg::OP_LOOKUP: begin
                            if (!r_hit) begin
                                o_res.status = krt_pkg::STAT_MISSING;
                            end else begin
                                o_res.salary = r_hit_rec.salary;
                                o_res.sex    = r_hit_rec.sex;
                                o_res.sector = r_hit_rec.sector;
                            end
                        end
                        default: begin
                            o_res.status = krt_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = krt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/keyed_record_table.sv */
// ----------------------------------------------------------------------------
// keyed_record_table: fixed-capacity keyed record table
// Clear, insert, delete, update salary and lookup on ENTRIES records, one
// result per request, held in an output register until taken.
//
//   channel   dir  tdata (low bit up)                         tuser
//   s_axis    in   key 32, salary 32, sex 1, sector 8, pad 7  op 3
//   m_axis    out  status 2, salary 32, sex 1, sector 8, pad 5  -
//
// A request runs as: accept, one store read per slot, one compare of the
// last slot, write back. Clear writes every slot in turn instead.
// The store ports walk the slots one a cycle, a read or a write per slot.
// After reset a clearing pass writes every slot before tready rises.
// A new request is taken while the previous result waits; a result waits
// for the output register to free before the store is written back.
// ----------------------------------------------------------------------------
module keyed_record_table #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,  // key, salary_in, sex_in, sector_in, zero pad
    input  logic [2:0]  i_s_axis_tuser,  // op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata   // status, salary_out, sex_out, sector_out, zero pad
);

    localparam int unsigned AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned REC_W = $bits(krt_pkg::t_rec);

    logic                 w_ram_we;
    logic [AW-1:0]        w_ram_waddr;
    krt_pkg::t_rec        w_ram_wdata;
    logic                 w_ram_re;
    logic [AW-1:0]        w_ram_raddr;
    logic [REC_W-1:0]     w_ram_rdata;
    krt_pkg::t_result     w_res;
    logic                 w_res_free;
    logic                 r_ovalid, n_ovalid;
    logic [47:0]          r_odata;

    krt_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (REC_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    krt_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_axis_tvalid),
        .o_req_ready  (o_s_axis_tready),
        .i_req_op     (i_s_axis_tuser),
        .i_req_key    (i_s_axis_tdata[31:0]),
        .i_req_salary (i_s_axis_tdata[63:32]),
        .i_req_sex    (i_s_axis_tdata[64]),
        .i_req_sector (i_s_axis_tdata[72:65]),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_re     (w_ram_re),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (krt_pkg::t_rec'(w_ram_rdata)),
        .i_res_free   (w_res_free),
        .o_res        (w_res)
    );

    assign w_res_free = !r_ovalid || i_m_axis_tready;

    always_comb begin
        n_ovalid = r_ovalid;
        if (w_res.valid) begin
            n_ovalid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_odata <= {5'd0, w_res.sector, w_res.sex, w_res.salary, w_res.status};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule
